// ===== src/gjk_pkg.sv =====
// Shared types, constants and width helpers for the GJK simplex update block.
package gjk_pkg;

    // default coordinate width and fixed field widths
    localparam int COORD_BITS_DEF = 16;
    localparam int FIELD_W        = 16;
    localparam int DIR_W          = 63;
    localparam int STEP_W         = 11;
    localparam logic [STEP_W-1:0] MAX_STEPS_RST = 11'd16;

    // result status codes
    typedef enum logic [1:0] {
        ST_CONT  = 2'd0,
        ST_SEP   = 2'd1,
        ST_HIT   = 2'd2,
        ST_LIMIT = 2'd3
    } t_status;

    // request to the shared vector unit
    typedef struct packed {
        logic start;
        logic is_dot;
        logic neg;
    } t_vop_req;

    // response from the shared vector unit
    typedef struct packed {
        logic done;
        logic neg;
        logic pos;
    } t_vop_rsp;

    // width of a point difference
    function automatic int diff_w(input int coord_bits);
        return coord_bits + 1;
    endfunction

    // width of a cross product of a difference cross product with a difference
    function automatic int wide_w(input int coord_bits);
        return 3 * coord_bits + 5;
    endfunction

endpackage

// ===== src/gjk_vop.sv =====
// Shared vector unit: cross or dot product on one split multiplier and accumulator.
module gjk_vop import gjk_pkg::*; #(
    parameter  int COORD_BITS = COORD_BITS_DEF,
    localparam int DW = diff_w(COORD_BITS),
    localparam int WW = wide_w(COORD_BITS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_vop_req             i_req,
    input  logic signed [WW-1:0] i_u [3],
    input  logic signed [DW-1:0] i_v [3],
    output t_vop_rsp             o_rsp,
    output logic signed [WW-1:0] o_res [3]
);

    localparam int H  = WW / 2;
    localparam int MA = H + 1;
    localparam int PW = MA + DW;
    localparam int AW = WW + DW + 3;

    logic                 r_busy;
    logic                 r_half;
    logic [2:0]           r_idx;
    logic                 r_pv;
    logic                 r_done;
    logic signed [PW-1:0] r_prod;
    logic                 r_phi;
    logic                 r_pneg;
    logic                 r_pclr;
    logic                 r_plast;
    logic                 r_pfin;
    logic [1:0]           r_pcomp;
    logic signed [AW-1:0] r_acc;
    logic                 r_sneg;
    logic                 r_spos;
    logic signed [WW-1:0] r_res [3];

    logic [1:0]           ui, vi, comp, nx, nz;
    logic                 sub, clr, last, fin;
    logic signed [WW-1:0] u_sel;
    logic signed [MA-1:0] a_op;
    logic signed [PW-1:0] n_prod;
    logic signed [AW-1:0] shifted, term, n_acc;

    // term sequencing: dot walks x,y,z; cross walks two terms per component
    always_comb begin
        nx = 2'd1;
        nz = 2'd2;
        if (i_req.is_dot) begin
            ui   = r_idx[1:0];
            vi   = r_idx[1:0];
            sub  = 1'b0;
            clr  = (r_idx == 3'd0);
            last = (r_idx == 3'd2);
            fin  = (r_idx == 3'd2);
            comp = 2'd0;
        end else begin
            case (r_idx[2:1])
                2'd0: begin
                    nx = 2'd1;
                    nz = 2'd2;
                end
                2'd1: begin
                    nx = 2'd2;
                    nz = 2'd0;
                end
                default: begin
                    nx = 2'd0;
                    nz = 2'd1;
                end
            endcase
            ui   = r_idx[0] ? nz : nx;
            vi   = r_idx[0] ? nx : nz;
            sub  = r_idx[0];
            clr  = !r_idx[0];
            last = r_idx[0];
            fin  = (r_idx == 3'd5);
            comp = r_idx[2:1];
        end
    end

    // split operand: low half unsigned, high half signed
    always_comb begin
        u_sel  = i_u[ui];
        a_op   = r_half ? MA'($signed(u_sel[WW-1:H])) : $signed({1'b0, u_sel[H-1:0]});
        n_prod = PW'(a_op) * PW'(i_v[vi]);
    end

    // accumulate the registered partial product
    always_comb begin
        shifted = r_phi ? (AW'(r_prod) <<< H) : AW'(r_prod);
        term    = r_pneg ? -shifted : shifted;
        n_acc   = (r_pclr ? AW'(0) : r_acc) + term;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
            r_half <= 1'b0;
            r_idx  <= 3'd0;
        end else begin
            r_pv   <= r_busy;
            r_done <= r_pv && r_pfin;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_idx  <= 3'd0;
                r_half <= 1'b0;
            end else if (r_busy) begin
                r_half <= !r_half;
                if (r_half) begin
                    r_idx <= r_idx + 3'd1;
                    if (fin) begin
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    // product stage and accumulator
    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_phi   <= r_half;
        r_pneg  <= sub ^ i_req.neg;
        r_pclr  <= clr && !r_half;
        r_plast <= last && r_half;
        r_pfin  <= fin && r_half;
        r_pcomp <= comp;
        if (r_pv) begin
            r_acc <= n_acc;
            if (r_plast) begin
                r_res[r_pcomp] <= WW'(n_acc);
            end
            if (r_pfin) begin
                r_sneg <= n_acc[AW-1];
                r_spos <= !n_acc[AW-1] && (n_acc != AW'(0));
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.neg  = r_sneg;
    assign o_rsp.pos  = r_spos;
    assign o_res      = r_res;

endmodule

// ===== src/gjk_simplex_update_unit.sv =====
// Top level of the GJK simplex update block: simplex store, case sequencer, stream ports.
//
// One support point per input word; one result word (status and next search direction) per
// input word. All products go through one shared multiplier of about (1.5*COORD_BITS+3) by
// (COORD_BITS+1) bits, used twice per product (low and high half of the wide operand) with a
// registered product feeding an accumulator. A start word, or a word after a finished test,
// goes straight to its result word; a further point first runs a dot product test and, unless
// it separates, then for two or more points the line, triangle or tetrahedron rule, all as
// chained products on the shared unit. The input is not ready while an item is in work or its
// result waits. The max_steps register is written on its own channel, which is always ready.
module gjk_simplex_update_unit import gjk_pkg::*; #(
    parameter  int COORD_BITS = COORD_BITS_DEF,
    localparam int DW = diff_w(COORD_BITS),
    localparam int WW = wide_w(COORD_BITS),
    localparam int CX = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: max_steps
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [STEP_W-1:0] i_cfg_data,
    // input stream
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [47:0]       i_s_tdata,    // point_x, point_y, point_z
    input  logic [0:0]        i_s_tuser,    // op
    // result stream
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [191:0]      o_m_tdata,    // dir_x, dir_y, dir_z, zero pad
    output logic [1:0]        o_m_tuser     // status
);

    typedef enum logic [19:0] {
        S_IDLE = 20'h00001,
        S_DOTP = 20'h00002,
        S_LINE = 20'h00004,
        S_TW1  = 20'h00008,
        S_TW2  = 20'h00010,
        S_TABC = 20'h00020,
        S_TACX = 20'h00040,
        S_TACD = 20'h00080,
        S_TACO = 20'h00100,
        S_TABX = 20'h00200,
        S_TABD = 20'h00400,
        S_FACE = 20'h00800,
        S_Q1X  = 20'h01000,
        S_Q1D  = 20'h02000,
        S_Q2X  = 20'h04000,
        S_Q2D  = 20'h08000,
        S_Q3X  = 20'h10000,
        S_Q3D  = 20'h20000,
        S_FIN  = 20'h40000,
        S_OUT  = 20'h80000
    } t_state;

    typedef enum logic [2:0] {U_DIR, U_AB, U_AC, U_AD, U_ABC, U_T} t_usel;
    typedef enum logic [2:0] {V_P, V_AO, V_AB, V_AC, V_AD} t_vsel;

    t_state                       r_state;
    logic                         r_wait;
    logic [2:0]                   r_count;
    logic [STEP_W-1:0]            r_step;
    logic [STEP_W-1:0]            r_max;
    t_status                      r_fin;
    logic signed [COORD_BITS-1:0] r_p  [3];
    logic signed [COORD_BITS-1:0] r_pa [3];
    logic signed [COORD_BITS-1:0] r_pb [3];
    logic signed [COORD_BITS-1:0] r_pc [3];
    logic signed [COORD_BITS-1:0] r_pd [3];
    logic signed [WW-1:0]         r_abc [3];
    logic signed [WW-1:0]         r_t   [3];
    logic signed [DIR_W-1:0]      r_dir [3];

    logic signed [COORD_BITS-1:0] in_p [3];
    logic [CX-1:0]                raw  [3];
    logic signed [DW-1:0]         ao [3], ab [3], ac [3], ad [3], pv [3];
    logic signed [WW-1:0]         u_vec [3];
    logic signed [DW-1:0]         v_vec [3];
    logic signed [WW-1:0]         vop_res [3];
    t_usel                        usel;
    t_vsel                        vsel;
    t_vop_req                     vop_req;
    t_vop_rsp                     vop_rsp;
    logic                         op_state;
    logic [2:0]                   cnt_inc;
    logic [STEP_W-1:0]            n_step;

    // field unpacking and simplex differences
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            raw[k]  = CX'(i_s_tdata[FIELD_W*k +: FIELD_W]);
            in_p[k] = $signed(raw[k][COORD_BITS-1:0]);
            ao[k]   = -DW'(r_pa[k]);
            ab[k]   = DW'(r_pb[k]) - DW'(r_pa[k]);
            ac[k]   = DW'(r_pc[k]) - DW'(r_pa[k]);
            ad[k]   = DW'(r_pd[k]) - DW'(r_pa[k]);
            pv[k]   = DW'(r_p[k]);
        end
    end

    // operand selection per sequencer step
    always_comb begin
        usel           = U_AB;
        vsel           = V_AO;
        vop_req.start  = op_state && !r_wait;
        vop_req.is_dot = 1'b0;
        vop_req.neg    = 1'b0;
        case (r_state)
            S_DOTP: begin
                usel           = U_DIR;
                vsel           = V_P;
                vop_req.is_dot = 1'b1;
            end
            S_LINE: vop_req.is_dot = 1'b1;
            S_TW1:  vsel = V_AO;
            S_TW2: begin
                usel = U_T;
                vsel = V_AB;
            end
            S_TABC: vsel = V_AC;
            S_TACX: begin
                usel = U_ABC;
                vsel = V_AC;
            end
            S_TACO: begin
                usel           = U_AC;
                vop_req.is_dot = 1'b1;
            end
            S_TABX: begin
                usel        = U_ABC;
                vsel        = V_AB;
                vop_req.neg = 1'b1;
            end
            S_FACE: begin
                usel           = U_ABC;
                vop_req.is_dot = 1'b1;
            end
            S_Q1X: vsel = V_AD;
            S_Q2X: begin
                usel = U_AC;
                vsel = V_AB;
            end
            S_Q3X: begin
                usel = U_AD;
                vsel = V_AC;
            end
            S_TACD, S_TABD, S_Q1D, S_Q2D, S_Q3D: begin
                usel           = U_T;
                vop_req.is_dot = 1'b1;
            end
            default: ;
        endcase
    end

    // operand muxes
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (usel)
                U_DIR:   u_vec[k] = WW'(r_dir[k]);
                U_AB:    u_vec[k] = WW'(ab[k]);
                U_AC:    u_vec[k] = WW'(ac[k]);
                U_AD:    u_vec[k] = WW'(ad[k]);
                U_ABC:   u_vec[k] = r_abc[k];
                U_T:     u_vec[k] = r_t[k];
                default: u_vec[k] = WW'(0);
            endcase
            case (vsel)
                V_P:     v_vec[k] = pv[k];
                V_AO:    v_vec[k] = ao[k];
                V_AB:    v_vec[k] = ab[k];
                V_AC:    v_vec[k] = ac[k];
                V_AD:    v_vec[k] = ad[k];
                default: v_vec[k] = DW'(0);
            endcase
        end
    end

    assign op_state      = !(r_state == S_IDLE || r_state == S_FIN || r_state == S_OUT);
    assign cnt_inc       = (r_count == 3'd4) ? 3'd4 : r_count + 3'd1;
    assign n_step        = r_step + STEP_W'(1);

    gjk_vop #(.COORD_BITS(COORD_BITS)) u_vop (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (vop_req),
        .i_u     (u_vec),
        .i_v     (v_vec),
        .o_rsp   (vop_rsp),
        .o_res   (vop_res)
    );

    // sequencer and simplex state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_count  <= 3'd0;
            r_step   <= '0;
            r_max    <= MAX_STEPS_RST;
            r_fin    <= ST_CONT;
            r_dir[0] <= '0;
            r_dir[1] <= '0;
            r_dir[2] <= DIR_W'(1);
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            if (vop_req.start) begin
                r_wait <= 1'b1;
            end else if (vop_rsp.done) begin
                r_wait <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_p <= in_p;
                        if (!i_s_tuser[0]) begin
                            r_pa    <= in_p;
                            r_count <= 3'd1;
                            r_step  <= STEP_W'(1);
                            for (int k = 0; k < 3; k++) begin
                                r_dir[k] <= DIR_W'(-DW'(in_p[k]));
                            end
                            r_fin   <= (STEP_W'(1) >= r_max) ? ST_LIMIT : ST_CONT;
                            r_state <= S_OUT;
                        end else if (r_fin != ST_CONT) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_DOTP;
                        end
                    end
                end
                S_DOTP: begin
                    if (vop_rsp.done) begin
                        if (vop_rsp.neg) begin
                            r_fin   <= ST_SEP;
                            r_state <= S_OUT;
                        end else begin
                            // push at the front
                            r_pd    <= r_pc;
                            r_pc    <= r_pb;
                            r_pb    <= r_pa;
                            r_pa    <= r_p;
                            r_count <= cnt_inc;
                            case (cnt_inc)
                                3'd2:    r_state <= S_LINE;
                                3'd3:    r_state <= S_TABC;
                                3'd4: begin
                                    r_count <= 3'd3;
                                    r_state <= S_Q1X;
                                end
                                default: r_state <= S_FIN;
                            endcase
                        end
                    end
                end
                // line rule, also the triangle's edge AB region
                S_LINE: begin
                    if (vop_rsp.done) begin
                        if (vop_rsp.pos) begin
                            r_state <= S_TW1;
                        end else begin
                            r_count <= 3'd1;
                            for (int k = 0; k < 3; k++) begin
                                r_dir[k] <= DIR_W'(ao[k]);
                            end
                            r_state <= S_FIN;
                        end
                    end
                end
                // direction toward the origin from edge AB
                S_TW1: begin
                    if (vop_rsp.done) begin
                        r_t     <= vop_res;
                        r_state <= S_TW2;
                    end
                end
                S_TW2: begin
                    if (vop_rsp.done) begin
                        for (int k = 0; k < 3; k++) begin
                            r_dir[k] <= DIR_W'(vop_res[k]);
                        end
                        r_state <= S_FIN;
                    end
                end
                // triangle rule
                S_TABC: begin
                    if (vop_rsp.done) begin
                        r_abc   <= vop_res;
                        r_state <= S_TACX;
                    end
                end
                S_TACX: begin
                    if (vop_rsp.done) begin
                        r_t     <= vop_res;
                        r_state <= S_TACD;
                    end
                end
                S_TACD: begin
                    if (vop_rsp.done) begin
                        r_state <= vop_rsp.pos ? S_TACO : S_TABX;
                    end
                end
                S_TACO: begin
                    if (vop_rsp.done) begin
                        r_count <= 3'd2;
                        if (vop_rsp.pos) begin
                            r_pb    <= r_pc;
                            r_state <= S_TW1;
                        end else begin
                            r_state <= S_LINE;
                        end
                    end
                end
                S_TABX: begin
                    if (vop_rsp.done) begin
                        r_t     <= vop_res;
                        r_state <= S_TABD;
                    end
                end
                S_TABD: begin
                    if (vop_rsp.done) begin
                        if (vop_rsp.pos) begin
                            r_count <= 3'd2;
                            r_state <= S_LINE;
                        end else begin
                            r_state <= S_FACE;
                        end
                    end
                end
                S_FACE: begin
                    if (vop_rsp.done) begin
                        if (vop_rsp.pos) begin
                            for (int k = 0; k < 3; k++) begin
                                r_dir[k] <= DIR_W'(r_abc[k]);
                            end
                        end else begin
                            r_pb <= r_pc;
                            r_pc <= r_pb;
                            for (int k = 0; k < 3; k++) begin
                                r_dir[k] <= -DIR_W'(r_abc[k]);
                            end
                        end
                        r_state <= S_FIN;
                    end
                end
                // tetrahedron rule: three faces through A
                S_Q1X: begin
                    if (vop_rsp.done) begin
                        r_t     <= vop_res;
                        r_state <= S_Q1D;
                    end
                end
                S_Q1D: begin
                    if (vop_rsp.done) begin
                        if (vop_rsp.neg) begin
                            r_pc    <= r_pd;
                            r_state <= S_TABC;
                        end else begin
                            r_state <= S_Q2X;
                        end
                    end
                end
                S_Q2X: begin
                    if (vop_rsp.done) begin
                        r_t     <= vop_res;
                        r_state <= S_Q2D;
                    end
                end
                S_Q2D: begin
                    if (vop_rsp.done) begin
                        r_state <= vop_rsp.neg ? S_TABC : S_Q3X;
                    end
                end
                S_Q3X: begin
                    if (vop_rsp.done) begin
                        r_t     <= vop_res;
                        r_state <= S_Q3D;
                    end
                end
                S_Q3D: begin
                    if (vop_rsp.done) begin
                        if (!vop_rsp.neg) begin
                            r_count <= 3'd4;
                            r_fin   <= ST_HIT;
                            r_state <= S_OUT;
                        end else begin
                            r_pb    <= r_pc;
                            r_pc    <= r_pd;
                            r_state <= S_TABC;
                        end
                    end
                end
                // step count and limit
                S_FIN: begin
                    r_step <= n_step;
                    if (n_step >= r_max) begin
                        r_fin <= ST_LIMIT;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ports
    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = (r_state == S_OUT);
    assign o_m_tdata   = {3'b000, r_dir[2], r_dir[1], r_dir[0]};
    assign o_m_tuser   = r_fin;

`ifndef ASSERT_OFF
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while a result is pending");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("simplex point count above four");
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vop_rsp.done |-> r_wait)
        else $error("vector unit done without a request");
    a_start_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vop_req.start |=> !vop_req.start)
        else $error("vector unit started twice in a row");
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready) |=> o_s_tready)
        else $error("not ready after result word taken");
`endif

endmodule
